### hdl/ovle_pkg.sv
// ovle_pkg: shared constants and code types for the ordered value list engine.
// Used by ordered_value_list_engine and ovle_checker; depends on nothing.
package ovle_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W_DEF   = 32;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam req_code_type REQ_INSERT = 2'd0;
   localparam req_code_type REQ_FIND   = 2'd1;
   localparam req_code_type REQ_DELETE = 2'd2;
   localparam req_code_type REQ_CLEAR  = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_MISSING = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

endpackage

### hdl/ordered_value_list_engine.sv
// ordered_value_list_engine: bounded unsorted list kept in insertion order,
// held in one synchronous memory. Depends on ovle_pkg.
//
//   channel   ports                                   handshake
//   request   req_type, req_value                     start && !busy
//   result    rsp_status, rsp_position, rsp_length    rsp_valid, one cycle
//
// Insert, clear, and find/delete on an empty list: result in the cycle after accept.
// Find: one memory read per cycle, entries scanned in order from the oldest.
// Delete: scan to the match, then one entry moved per cycle until the gap is closed.
// Rate is set by the single read port of the entry memory.
// Reset clears the state, the count and the result strobe; the entry memory needs no clearing pass.
// Results cannot be stalled; a new item may be accepted while a result is shown.
module ordered_value_list_engine
   import ovle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int DATA_W   = DATA_W_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [POS_W-1:0]    rsp_position,
   output logic [POS_W-1:0]    rsp_length
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] value_ff, value_in;
   req_code_type      op_ff, op_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] req_value_ext;
   logic [CNT_W-1:0]  idx_next_cnt;
   logic [CNT_W-1:0]  idx_next2_cnt;
   logic              hit;

   assign req_value_ext = DATA_W'(req_value);
   assign idx_next_cnt  = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_next2_cnt = CNT_W'(idx_ff) + CNT_W'(2);
   assign hit           = (rd_data_ff == value_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rd_addr      = '0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_type;
               value_in = req_value_ext;
               unique case (req_type)
                  REQ_INSERT: begin
                     pos_in       = '0;
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[IDX_W-1:0];
                        mem_wdata = req_value_ext;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_FIND, REQ_DELETE: begin
                     if (count_ff == '0) begin
                        status_in    = ST_MISSING;
                        pos_in       = '0;
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in     = '0;
                     status_in    = ST_OK;
                     pos_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               pos_in    = idx_next_cnt;
               status_in = ST_OK;
               if (op_ff == REQ_FIND) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (idx_next_cnt == count_ff) begin
                  // match is the newest entry: nothing to move
                  count_in     = count_ff - CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  rd_addr  = idx_ff + IDX_W'(1);
                  state_in = S_SHIFT;
               end
            end else if (idx_next_cnt == count_ff) begin
               status_in    = ST_MISSING;
               pos_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_addr = idx_ff + IDX_W'(1);
               idx_in  = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT: begin
            // rd_data_ff holds entry idx+1; it moves down to idx
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = rd_data_ff;
            if (idx_next2_cnt < count_ff) begin
               rd_addr = idx_ff + IDX_W'(2);
               idx_in  = idx_ff + IDX_W'(1);
            end else begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      op_ff     <= op_in;
      status_ff <= status_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = POS_W'(pos_ff);
   assign rsp_length   = POS_W'(count_ff);

endmodule

### hdl/ovle_checker.sv
// ovle_checker: port-level assertions for ordered_value_list_engine, bound to it.
// Depends on ovle_pkg.
module ovle_checker
   import ovle_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [REQ_W-1:0]    req_type,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [POS_W-1:0]    rsp_position,
   input logic [POS_W-1:0]    rsp_length
);

   // clear always answers in the next cycle with an empty list
   a_clear_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_CLEAR) |=> (rsp_valid && rsp_length == '0))
      else $error("clear did not answer next cycle with length zero");

   // inserts never enter the scan path
   a_insert_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_INSERT) |=> (rsp_valid && !busy))
      else $error("insert did not answer next cycle");

   // no result is shown while a scan or shift is running
   a_no_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while busy");

   // length moves only together with a result
   a_length_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !$stable(rsp_length) |-> rsp_valid)
      else $error("length changed without a result");

   // rejected or missing items carry no position
   a_no_pos_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_MISSING || rsp_status == ST_FULL))
         |-> (rsp_position == '0))
      else $error("position set on a failed item");

endmodule

bind ordered_value_list_engine ovle_checker u_ovle_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_type     (req_type),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position),
   .rsp_length   (rsp_length)
);
